// ----- rtl/core/hpq_pkg.sv -----
// heap priority queue package: sizes, entry and transaction structs, status codes
// and the key compare; used by the top level and the checker under rtl/core
// no dependencies
`default_nettype none

package hpq_pkg;

  localparam int DEPTH     = 1024;
  localparam int KEY_BITS  = 32;
  localparam int DATA_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CHILD_W   = ADDR_W + 1;
  localparam int ENTRY_W   = KEY_BITS + DATA_BITS;
  localparam int OCC_W     = 11;

  localparam logic       KIND_PUSH = 1'b0;
  localparam logic       KIND_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] key;
    logic [31:0] payload;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      out_key;
    logic [31:0]      out_payload;
    logic [OCC_W-1:0] occupancy;
  } out_t;

  // strict compare: a ahead of b
  function automatic logic better(input logic order, input logic [KEY_BITS-1:0] a,
                                  input logic [KEY_BITS-1:0] b);
    better = order ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/binary_heap_priority_queue_unit.sv -----
// binary heap priority queue: top level with the sift sequencer around the heap ram
// depends on hpq_pkg and hpq_ram
//
//   channel   handshake          payload        direction
//   command   start / busy       cmd (in_t)     in
//   result    done (1 cycle)     result (out_t) out
//   config    cfg_we             cfg_wdata      in
//
// a push climbs from the new slot to the root through S_UP_RD (read parent) and
// S_UP_CMP (compare, write) per level, ending in S_WB; a pop fetches root and last
// entry (S_POP_LD), then descends through S_DN_RD and S_DN_CMP per level; refused
// operations report from idle; every step works on the single heap ram.
// done rises in the cycle after the final write; the result cannot be stalled.
// rst is synchronous: count, order and control clear, the ram contents are left alone.
`default_nettype none

module binary_heap_priority_queue_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire hpq_pkg::in_t cmd,
  output logic              done,
  output hpq_pkg::out_t     result,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata
);
  import hpq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_UP_RD  = 7'b0000010,
    S_UP_CMP = 7'b0000100,
    S_WB     = 7'b0001000,
    S_POP_LD = 7'b0010000,
    S_DN_RD  = 7'b0100000,
    S_DN_CMP = 7'b1000000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic               heap_order;
  logic [ADDR_W-1:0]  pos;
  entry_t             hold;
  logic               has_right;
  out_t               res;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  entry_t             wdata;
  logic [ADDR_W-1:0]  raddr_a;
  logic [ADDR_W-1:0]  raddr_b;
  entry_t             rdata_a;
  entry_t             rdata_b;

  logic [CNT_W-1:0]   count_inc;
  logic [CNT_W-1:0]   count_dec;
  logic [ADDR_W-1:0]  parent;
  logic [CHILD_W-1:0] left;
  logic [CHILD_W-1:0] right;
  logic               accept;
  logic               up_swap;
  logic               pick_right;
  entry_t             pick_e;
  logic [ADDR_W-1:0]  pick_addr;
  logic               stop;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign count_inc = count + CNT_W'(1);
  assign count_dec = count - CNT_W'(1);
  assign parent    = (pos - ADDR_W'(1)) >> 1;
  assign left      = {pos, 1'b1};
  assign right     = left + CHILD_W'(1);

  assign up_swap    = better(heap_order, hold.key, rdata_a.key);
  assign pick_right = has_right && better(heap_order, rdata_b.key, rdata_a.key);
  assign pick_e     = pick_right ? rdata_b : rdata_a;
  assign pick_addr  = pick_right ? right[ADDR_W-1:0] : left[ADDR_W-1:0];
  assign stop       = better(heap_order, hold.key, pick_e.key);

  always_comb begin
    we      = 1'b0;
    waddr   = pos;
    wdata   = hold;
    raddr_a = parent;
    raddr_b = right[ADDR_W-1:0];
    unique case (state)
      S_IDLE: begin
        // fetch root and last entry in case this is a pop
        raddr_a = '0;
        raddr_b = count_dec[ADDR_W-1:0];
      end
      S_UP_RD: begin
        raddr_a = parent;
      end
      S_UP_CMP: begin
        we    = 1'b1;
        wdata = up_swap ? rdata_a : hold;
      end
      S_WB: begin
        we = 1'b1;
      end
      S_POP_LD: begin
        we = 1'b0;
      end
      S_DN_RD: begin
        raddr_a = left[ADDR_W-1:0];
        raddr_b = right[ADDR_W-1:0];
      end
      S_DN_CMP: begin
        we    = 1'b1;
        wdata = stop ? hold : pick_e;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  hpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      heap_order <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        heap_order <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res.out_key     <= '0;
            res.out_payload <= '0;
            if (cmd.kind == KIND_PUSH) begin
              if (count >= CNT_W'(DEPTH)) begin
                res.status    <= ST_FULL;
                res.occupancy <= OCC_W'(count);
                done          <= 1'b1;
              end else begin
                res.status    <= ST_OK;
                res.occupancy <= OCC_W'(count_inc);
                hold.key      <= cmd.key[KEY_BITS-1:0];
                hold.payload  <= cmd.payload[DATA_BITS-1:0];
                pos           <= count[ADDR_W-1:0];
                count         <= count_inc;
                state         <= (count == '0) ? S_WB : S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                res.status    <= ST_EMPTY;
                res.occupancy <= '0;
                done          <= 1'b1;
              end else begin
                res.status    <= ST_OK;
                res.occupancy <= OCC_W'(count_dec);
                count         <= count_dec;
                state         <= S_POP_LD;
              end
            end
          end
        end
        S_UP_RD: begin
          state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          // the entry left behind at pos is final; keep walking with the other one
          if (!up_swap) begin
            hold <= rdata_a;
          end
          pos   <= parent;
          state <= (parent == '0) ? S_WB : S_UP_RD;
        end
        S_WB: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_POP_LD: begin
          res.out_key     <= 32'(rdata_a.key);
          res.out_payload <= 32'(rdata_a.payload);
          hold            <= rdata_b;
          pos             <= '0;
          state           <= S_DN_RD;
        end
        S_DN_RD: begin
          if (left >= CHILD_W'(count)) begin
            state <= S_WB;
          end else begin
            has_right <= (right < CHILD_W'(count));
            state     <= S_DN_CMP;
          end
        end
        S_DN_CMP: begin
          if (stop) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            pos   <= pick_addr;
            state <= S_DN_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result = res;

endmodule

`default_nettype wire

// ----- rtl/core/hpq_ram.sv -----
// generic ram: one write port, two read ports, registered read data
// no dependencies
`default_nettype none

module hpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/core/hpq_checker.sv -----
// port-level checker for the heap priority queue, bound to the top level
// depends on hpq_pkg and binary_heap_priority_queue_unit
`default_nettype none

module hpq_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire hpq_pkg::out_t result
);
  import hpq_pkg::*;

  // a result transaction only ever closes an operation
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // every accepted command either runs or reports at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> (busy || done))
    else $error("accepted command dropped");

  // refused operations carry no entry
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
      (done && result.status != ST_OK) |-> (result.out_key == '0 && result.out_payload == '0))
    else $error("refused operation returned data");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
      (done && result.status == ST_EMPTY) |-> (result.occupancy == '0))
    else $error("empty pop with nonzero occupancy");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
      done |-> (result.occupancy <= OCC_W'(DEPTH)))
    else $error("occupancy beyond depth");

endmodule

bind binary_heap_priority_queue_unit hpq_checker u_hpq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ----- test/binary_heap_priority_queue_unit_tb.sv -----
// self-checking testbench for the binary heap priority queue unit
// predicts every pop, push and refusal with a software heap and checks each result strobe
// depends on hpq_pkg and binary_heap_priority_queue_unit
`default_nettype none

module binary_heap_priority_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpq_pkg::*;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  cmd;
  logic done;
  out_t result;
  logic cfg_we;
  logic cfg_wdata;

  binary_heap_priority_queue_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // software copy of the heap
  entry_t      heap_mem [DEPTH];
  int unsigned heap_cnt;
  logic        heap_ord;

  out_t awaited_results [$];

  int unsigned errors;
  int unsigned n_checked;
  int unsigned n_push;
  int unsigned n_pop;
  int unsigned n_full;
  int unsigned n_empty;
  int unsigned n_order_writes;
  int unsigned peak_occ;
  bit          steady;

  function automatic logic ahead(input entry_t a, input entry_t b);
    ahead = heap_ord ? (a.key > b.key) : (a.key < b.key);
  endfunction

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    entry_t t;
    t           = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  // applies one transaction to the software heap and returns the result it causes
  function automatic out_t serve_op(input in_t c);
    out_t        r;
    int unsigned pos;
    int unsigned par;
    int unsigned cur;
    int unsigned kid;
    r = '0;
    if (c.kind == KIND_PUSH) begin
      if (heap_cnt >= DEPTH) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        heap_mem[heap_cnt].key     = c.key[KEY_BITS-1:0];
        heap_mem[heap_cnt].payload = c.payload[DATA_BITS-1:0];
        pos = heap_cnt;
        // walks every level, even after the entry has settled
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (ahead(heap_mem[pos], heap_mem[par])) swap_slots(par, pos);
          pos = par;
        end
        heap_cnt++;
        n_push++;
      end
    end else if (heap_cnt == 0) begin
      r.status = ST_EMPTY;
      n_empty++;
    end else begin
      r.out_key     = heap_mem[0].key;
      r.out_payload = heap_mem[0].payload;
      heap_cnt--;
      heap_mem[0] = heap_mem[heap_cnt];
      cur = 0;
      while (2 * cur + 1 < heap_cnt) begin
        kid = 2 * cur + 1;
        if (kid + 1 < heap_cnt && ahead(heap_mem[kid + 1], heap_mem[kid])) kid++;
        // on equal keys the entry keeps moving down
        if (ahead(heap_mem[cur], heap_mem[kid])) break;
        swap_slots(kid, cur);
        cur = kid;
      end
      n_pop++;
    end
    r.occupancy = OCC_W'(heap_cnt);
    if (heap_cnt > peak_occ) peak_occ = heap_cnt;
    return r;
  endfunction

  task automatic issue(input in_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    awaited_results.push_back(serve_op(c));
    if (!steady && $urandom_range(0, 99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic push_entry(input logic [31:0] k, input logic [31:0] p);
    in_t c;
    c.kind    = KIND_PUSH;
    c.key     = k;
    c.payload = p;
    issue(c);
  endtask

  task automatic pop_entry();
    in_t c;
    c.kind    = KIND_POP;
    c.key     = $urandom;
    c.payload = $urandom;
    issue(c);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_order(input logic v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    heap_ord  = v;
    n_order_writes++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", 32'(want.status), 32'(result.status));
        compare_field("out_key", want.out_key, result.out_key);
        compare_field("out_payload", want.out_payload, result.out_payload);
        compare_field("occupancy", 32'(want.occupancy), 32'(result.occupancy));
        n_checked++;
      end
    end
  end

  task automatic test_empty_pop();
    in_t c;
    c.kind    = KIND_POP;
    c.key     = 32'hFFFF_FFFF;
    c.payload = 32'h0;
    issue(c);
    c.key     = 32'h0;
    c.payload = 32'hFFFF_FFFF;
    issue(c);
  endtask

  task automatic test_min_order();
    push_entry(32'hFFFF_FFFF, 32'h0000_0000);
    push_entry(32'h0000_0000, 32'hFFFF_FFFF);
    // equal keys, payload tells which one comes out first
    push_entry(32'd5, 32'h1);
    push_entry(32'd5, 32'h2);
    push_entry(32'd5, 32'h3);
    push_entry(32'd1, 32'hA5A5_5A5A);
    repeat (7) pop_entry();
  endtask

  task automatic test_max_order();
    set_order(1'b1);
    push_entry(32'd7, 32'h7);
    push_entry(32'hFFFF_FFFF, 32'h5A5A_A5A5);
    push_entry(32'd0, 32'h0);
    push_entry(32'd7, 32'h8);
    pop_entry();
    // order flips with entries still held
    set_order(1'b0);
    push_entry(32'd3, 32'h3);
    repeat (5) pop_entry();
  endtask

  task automatic test_full_heap();
    steady = 1'b1;
    set_order(1'b1);
    repeat (DEPTH) push_entry($urandom_range(0, 63), $urandom);
    push_entry($urandom, $urandom);
    push_entry(32'hFFFF_FFFF, $urandom);
    pop_entry();
    push_entry($urandom_range(0, 63), $urandom);
    set_order(1'b0);
    repeat (DEPTH + 1) pop_entry();
    steady = 1'b0;
  endtask

  function automatic logic [31:0] pick_key(input int style);
    case (style)
      0:       pick_key = $urandom;
      1:       pick_key = $urandom_range(0, 15);
      default: pick_key = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                               : 32'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic test_random();
    int push_pct;
    for (int ph = 0; ph < 6; ph++) begin
      set_order(ph < 2 ? ph[0] : 1'($urandom_range(0, 1)));
      steady   = (ph == 3);
      push_pct = ph[0] ? 40 : 80;
      repeat (75) begin
        if ($urandom_range(0, 99) < push_pct) push_entry(pick_key($urandom_range(0, 2)), $urandom);
        else pop_entry();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    heap_cnt  = 0;
    heap_ord  = 1'b0;
    steady    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_pop();
    test_min_order();
    test_max_order();
    test_full_heap();
    test_random();

    wait_idle();
    repeat (30) @(posedge clk);

    $display("covered %0d pushes, %0d pops, %0d refused full pushes, %0d empty pops",
             n_push, n_pop, n_full, n_empty);
    $display("%0d results checked, %0d order writes, peak occupancy %0d",
             n_checked, n_order_writes, peak_occ);
    if (errors == 0) begin
      $display("binary_heap_priority_queue_unit_tb: PASS");
    end else begin
      $display("binary_heap_priority_queue_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout at %0t", $time);
    $display("binary_heap_priority_queue_unit_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/hpq_pkg.sv
rtl/core/hpq_ram.sv
rtl/core/binary_heap_priority_queue_unit.sv
rtl/core/hpq_checker.sv
test/binary_heap_priority_queue_unit_tb.sv
